// ===== sv/assert_macros.svh =====
// Assertion macros used by the NTC port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/ntcm_pkg.sv =====
// ---------------------------------------------------------------------------
// NTC median-of-three package
// Shared types and constants for the thermistor temperature block.
// ---------------------------------------------------------------------------
package ntcm_pkg;
    localparam int FULL_SCALE = 26400;
    localparam int KELVIN_OFFSET_16THS = 4368;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_LOW  = 2'd1;
    localparam logic [1:0] STATUS_HIGH = 2'd2;

    localparam logic [1:0] REG_RREF = 2'd0;
    localparam logic [1:0] REG_BETA = 2'd1;
    localparam logic [1:0] REG_T0   = 2'd2;

    // Classified transaction passed from the front to the back.
    typedef struct packed {
        logic [14:0] median;
        logic [1:0]  status;
    } job_t;
endpackage

// ===== sv/ntc_median3_temperature.sv =====
// ---------------------------------------------------------------------------
// NTC thermistor temperature, median of three
// Converts groups of three converter samples into resistance and temperature.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// sample    in         sample_valid/stall    sample
// result    out        result_valid/stall    temperature, resistance, status
//
// A valid median passes through the bit-serial divider, which performs the
// resistance, ratio and temperature divisions in turn.
// A faulty median goes from the idle state straight to the output state.
// Reset clears the group position and the queue; held samples are not reset.
// The front stalls only while the two-entry queue is full.
module ntc_median3_temperature
    import ntcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [15:0] sample,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] temperature,
    output logic [23:0]        thermistor_resistance,
    output logic [1:0]         status
);
    logic [19:0] rref_reg;
    logic [13:0] beta_reg;
    logic [15:0] t0_reg;
    logic        job_valid, full, empty, pop, acc;
    job_t        job_in, job_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rref_reg <= 20'd10000;
            beta_reg <= 14'd3950;
            t0_reg   <= 16'd29815;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RREF: rref_reg <= cfg_data;
                REG_BETA: beta_reg <= cfg_data[13:0];
                REG_T0:   t0_reg <= cfg_data[15:0];
                default:  ;
            endcase
        end
    end

    assign sample_stall = full;
    assign acc = sample_valid && !full;

    ntcm_front u_front (
        .clk(clk), .rst_n(rst_n), .sample_valid(sample_valid), .sample(sample),
        .accept(acc), .job_valid(job_valid), .job(job_in)
    );

    ntcm_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(acc && job_valid), .din(job_in),
        .full(full), .empty(empty), .pop(pop), .dout(job_out)
    );

    ntcm_engine u_engine (
        .clk(clk), .rst_n(rst_n), .rref(rref_reg), .beta(beta_reg), .t0(t0_reg),
        .job_avail(!empty), .job(job_out), .job_pop(pop),
        .result_valid(result_valid), .result_stall(result_stall),
        .temperature(temperature), .thermistor_resistance(thermistor_resistance),
        .status(status)
    );
endmodule

// ===== sv/ntcm_front.sv =====
// ---------------------------------------------------------------------------
// NTC front end
// Collects samples in groups of three and classifies the median.
// ---------------------------------------------------------------------------
module ntcm_front
    import ntcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    input  logic signed [15:0] sample,
    input  logic               accept,
    output logic               job_valid,
    output job_t               job
);
    logic [1:0]         idx_reg;
    logic signed [15:0] h0_reg, h1_reg;
    logic signed [15:0] lo, hi, med;

    always_comb
    begin
        lo = (h0_reg < h1_reg) ? h0_reg : h1_reg;
        hi = (h0_reg < h1_reg) ? h1_reg : h0_reg;
        if (sample < lo)
            med = lo;
        else if (sample > hi)
            med = hi;
        else
            med = sample;
        job.median = med[14:0];
        if (med <= 16'sd0)
            job.status = STATUS_LOW;
        else if (med >= 16'sd26400)
            job.status = STATUS_HIGH;
        else
            job.status = STATUS_OK;
    end

    assign job_valid = sample_valid && (idx_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else if (accept)
            idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (accept && idx_reg == 2'd0)
            h0_reg <= sample;
        if (accept && idx_reg == 2'd1)
            h1_reg <= sample;
    end
endmodule

// ===== sv/ntcm_fifo.sv =====
// ---------------------------------------------------------------------------
// NTC job queue
// Two-entry queue between the front end and the compute engine.
// ---------------------------------------------------------------------------
module ntcm_fifo
    import ntcm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t din,
    output logic full,
    output logic empty,
    input  logic pop,
    output job_t dout
);
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= din;
    end
endmodule

// ===== sv/ntcm_engine.sv =====
// ---------------------------------------------------------------------------
// NTC compute engine
// Works out resistance, logarithm and temperature with one shared
// restoring divider, a squaring multiplier and several other multipliers.
// ---------------------------------------------------------------------------
module ntcm_engine
    import ntcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [19:0]        rref,
    input  logic [13:0]        beta,
    input  logic [15:0]        t0,
    input  logic               job_avail,
    input  job_t               job,
    output logic               job_pop,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] temperature,
    output logic [23:0]        thermistor_resistance,
    output logic [1:0]         status
);
    typedef enum logic [3:0] {
        S_IDLE, S_MULR, S_DIVR, S_RES, S_DIVX, S_NORM, S_ZINIT, S_SQ, S_SQR, S_LN,
        S_DEN, S_NUM, S_DIVT, S_FIN, S_OUT
    } state_t;

    state_t       state_reg;
    logic [14:0]  m_reg;
    logic [14:0]  up_reg;
    logic [5:0]   cnt_reg;
    logic [63:0]  dividend_reg;
    logic [63:0]  quo_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  divisor_reg;
    logic [23:0]  res_reg;
    logic [31:0]  ratio_reg;
    logic [4:0]   p_reg;
    logic [31:0]  z_reg;
    logic [63:0]  sq_reg;
    logic [15:0]  frac_reg;
    logic signed [31:0] lg_reg;
    logic signed [63:0] prod_reg;
    logic signed [39:0] l24_reg;
    logic signed [63:0] den_reg;
    logic [63:0]  num_reg;

    logic [64:0]  rem_sh;
    logic [64:0]  rem_sub;
    logic signed [63:0] l24_full;
    logic [4:0]   lead_pos;

    assign rem_sh  = {rem_reg, dividend_reg[63]};
    assign rem_sub = rem_sh - {1'b0, divisor_reg};
    assign l24_full = prod_reg >>> 22;
    assign job_pop = (state_reg == S_IDLE) && job_avail;
    assign result_valid = (state_reg == S_OUT);

    always_comb
    begin
        lead_pos = 5'd0;
        for (int i = 0; i < 32; i++)
            if (quo_reg[i])
                lead_pos = 5'(i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_avail)
                    begin
                        m_reg  <= job.median;
                        up_reg <= 15'(FULL_SCALE) - job.median;
                        status <= job.status;
                        if (job.status != STATUS_OK)
                        begin
                            temperature <= 16'sd0;
                            thermistor_resistance <= 24'd0;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_MULR;
                    end
                end
                S_MULR:
                begin
                    dividend_reg <= {29'd0, 35'(rref * up_reg)} << 29;
                    divisor_reg  <= {49'd0, m_reg};
                    rem_reg <= 64'd0;
                    quo_reg <= 64'd0;
                    cnt_reg <= 6'd35;
                    state_reg <= S_DIVR;
                end
                S_DIVR, S_DIVX, S_DIVT:
                begin
                    dividend_reg <= dividend_reg << 1;
                    if (!rem_sub[64])
                    begin
                        rem_reg <= rem_sub[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        if (state_reg == S_DIVR)
                            state_reg <= S_RES;
                        else if (state_reg == S_DIVX)
                            state_reg <= S_NORM;
                        else
                            state_reg <= S_FIN;
                    end
                end
                S_RES:
                begin
                    res_reg <= (quo_reg > 64'hFFFFFF) ? 24'hFFFFFF : quo_reg[23:0];
                    dividend_reg <= {1'b0, up_reg, 48'd0};
                    divisor_reg  <= {49'd0, m_reg};
                    rem_reg <= 64'd0;
                    quo_reg <= 64'd0;
                    cnt_reg <= 6'd32;
                    state_reg <= S_DIVX;
                end
                S_FIN:
                begin
                    thermistor_resistance <= res_reg;
                    status <= STATUS_OK;
                    if (den_reg <= 64'sd0)
                        temperature <= 16'sd32767;
                    else if ($signed(quo_reg) - 64'sd4368 > 64'sd32767)
                        temperature <= 16'sd32767;
                    else if ($signed(quo_reg) - 64'sd4368 < -64'sd32768)
                        temperature <= -16'sd32768;
                    else
                        temperature <= 16'(quo_reg - 64'd4368);
                    state_reg <= S_OUT;
                end
                S_NORM:
                begin
                    ratio_reg <= quo_reg[31:0];
                    p_reg <= lead_pos;
                    cnt_reg <= 6'd16;
                    frac_reg <= 16'd0;
                    state_reg <= S_ZINIT;
                end
                S_ZINIT:
                begin
                    z_reg <= 32'(({32'd0, ratio_reg} << 30) >> p_reg);
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    sq_reg <= {32'd0, z_reg} * {32'd0, z_reg};
                    state_reg <= S_SQR;
                end
                S_SQR:
                begin
                    if (sq_reg[63:30] >= 34'h80000000)
                    begin
                        z_reg <= 32'(sq_reg[63:31]);
                        frac_reg <= frac_reg | (16'd1 << (cnt_reg - 6'd1));
                    end
                    else
                        z_reg <= sq_reg[61:30];
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                        state_reg <= S_LN;
                    else
                        state_reg <= S_SQ;
                end
                S_LN:
                begin
                    lg_reg <= $signed({11'd0, p_reg, 16'd0}) - 32'sd1048576
                              + $signed({16'd0, frac_reg});
                    sq_reg <= 64'h2;
                    state_reg <= S_DEN;
                end
                S_DEN:
                begin
                    if (sq_reg == 64'h2)
                    begin
                        prod_reg <= 64'(lg_reg * $signed({2'b0, LN2_Q30}));
                        sq_reg <= 64'h3;
                    end
                    else if (sq_reg == 64'h3)
                    begin
                        // Truncation toward zero as the division by 2^22 requires.
                        if (prod_reg < 0 && prod_reg[21:0] != 22'd0)
                            l24_reg <= 40'(l24_full + 64'sd1);
                        else
                            l24_reg <= 40'(l24_full);
                        sq_reg <= 64'h4;
                    end
                    else if (sq_reg == 64'h4)
                    begin
                        prod_reg <= 64'($signed({1'b0, t0}) * l24_reg);
                        num_reg <= 64'({t0, 4'd0} * beta);
                        sq_reg <= 64'h5;
                    end
                    else
                    begin
                        den_reg <= $signed({19'd0, 21'(7'd100 * beta), 24'd0}) + prod_reg;
                        num_reg <= num_reg << 24;
                        state_reg <= S_NUM;
                    end
                end
                S_NUM:
                begin
                    // The counter covers 63 bits, so the dividend starts one bit up.
                    cnt_reg <= 6'd63;
                    dividend_reg <= (num_reg + {1'b0, den_reg[63:1]}) << 1;
                    divisor_reg <= den_reg;
                    rem_reg <= 64'd0;
                    quo_reg <= 64'd0;
                    if (den_reg <= 64'sd0)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_DIVT;
                end
                S_OUT:
                begin
                    if (!result_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/ntcm_checker.sv =====
// ---------------------------------------------------------------------------
// NTC port checker
// Checks the behaviour visible at the top-level ports.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module ntcm_checker
    import ntcm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [15:0] temperature,
    input logic [23:0]        thermistor_resistance,
    input logic [1:0]         status
);
    `ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(status))
    `ASSERT_IMPL(a_stat, clk, rst_n, result_valid, status != 2'd3)
    `ASSERT_IMPL(a_fault, clk, rst_n, result_valid && status != STATUS_OK, thermistor_resistance == 24'd0 && temperature == 16'sd0)
endmodule

bind ntc_median3_temperature ntcm_checker u_checker (
    .clk(clk), .rst_n(rst_n), .result_valid(result_valid),
    .result_stall(result_stall), .temperature(temperature),
    .thermistor_resistance(thermistor_resistance), .status(status)
);

// ===== verif/ntc_median3_temperature_test.sv =====
// ---------------------------------------------------------------------------
// NTC median-of-three temperature testbench
// Sends groups of three samples, predicts resistance, temperature and status
// from the median of each group and compares every result transaction.
// ---------------------------------------------------------------------------
module ntc_median3_temperature_test;
    import ntcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [23:0]        ohms;
        logic [1:0]         stat;
    } reading_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [19:0]        cfg_data;
    logic               sample_valid;
    logic               sample_stall;
    logic signed [15:0] sample;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [15:0] temperature;
    logic [23:0]        thermistor_resistance;
    logic [1:0]         status;

    reading_t   expected_readings[$];
    logic [19:0] rref_model;
    logic [13:0] beta_model;
    logic [15:0] t0_model;
    int          group_pos;
    logic signed [15:0] group_held[2];
    int          failures;
    int          idle_cycles = 0;
    bit          allow_idle;

    ntc_median3_temperature dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int log2_fix(longint unsigned x);
        int p;
        int frac;
        longint unsigned z;
        p = 0;
        frac = 0;
        for (int i = 0; i < 32; i++)
            if (x[i]) p = i;
        z = x << (30 - p);
        for (int i = 1; i <= 16; i++)
        begin
            z = (z * z) >> 30;
            if (z >= (64'd1 << 31))
            begin
                z = z >> 1;
                frac = frac | (1 << (16 - i));
            end
        end
        return (p - 16) * 65536 + frac;
    endfunction

    function automatic reading_t convert_median(int m);
        reading_t r;
        longint unsigned upper;
        longint unsigned res;
        longint unsigned ratio;
        longint l24;
        longint num;
        longint den;
        longint t;
        r = '0;
        if (m <= 0)
        begin
            r.stat = STATUS_LOW;
            return r;
        end
        if (m >= FULL_SCALE)
        begin
            r.stat = STATUS_HIGH;
            return r;
        end
        upper = FULL_SCALE - m;
        res = (longint'(rref_model) * upper) / m;
        if (res > 64'hFFFFFF) res = 64'hFFFFFF;
        ratio = (upper << 16) / m;
        l24 = (longint'(log2_fix(ratio)) * longint'(LN2_Q30)) / (64'sd1 <<< 22);
        num = 16 * longint'(t0_model) * longint'(beta_model) * (64'sd1 <<< 24);
        den = 100 * longint'(beta_model) * (64'sd1 <<< 24) + longint'(t0_model) * l24;
        if (den <= 0)
            t = 32767;
        else
        begin
            t = (num + den / 2) / den - KELVIN_OFFSET_16THS;
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
        end
        r.temp = t[15:0];
        r.ohms = res[23:0];
        r.stat = STATUS_OK;
        return r;
    endfunction

    function automatic void predict_sample(logic signed [15:0] s);
        int a;
        int b;
        int c;
        int tmp;
        if (group_pos < 2)
        begin
            group_held[group_pos] = s;
            group_pos++;
            return;
        end
        group_pos = 0;
        a = group_held[0];
        b = group_held[1];
        c = s;
        if (a > b) begin tmp = a; a = b; b = tmp; end
        if (b > c) begin tmp = b; b = c; c = tmp; end
        if (a > b) b = a;
        expected_readings.push_back(convert_median(b));
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        failures++;
    endtask

    task automatic send_sample(logic signed [15:0] s);
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        predict_sample(s);
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [19:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RREF: rref_model = val;
            REG_BETA: beta_model = val[13:0];
            REG_T0:   t0_model = val[15:0];
            default: ;
        endcase
    endtask

    task automatic send_group(int a, int b, int c);
        send_sample(a[15:0]);
        send_sample(b[15:0]);
        send_sample(c[15:0]);
    endtask

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 40));
            2: return 16'($urandom_range(26350, 26420));
            3: return 16'(0 - int'($urandom_range(0, 5)));
            default: return 16'($urandom_range(1, 26399));
        endcase
    endfunction

    task automatic test_directed();
        send_group(-32768, -32768, -32768);
        send_group(32767, 32767, 32767);
        send_group(0, 5, -3);
        send_group(26400, 26399, 30000);
        send_group(1, 1, 1);
        send_group(26399, 26399, 26399);
        send_group(13200, 100, 20000);
        send_group(300, 9000, 5000);
    endtask

    task automatic test_registers();
        write_register(REG_RREF, 20'd1000000);
        write_register(REG_BETA, 20'd10000);
        write_register(REG_T0, 20'd50000);
        send_group(1, 1, 1);
        send_group(26399, 26399, 26399);
        send_group(7000, 7000, 7000);
        wait_drained();
        write_register(REG_RREF, 20'd1);
        write_register(REG_BETA, 20'd1);
        write_register(REG_T0, 20'd1);
        write_register(2'd3, 20'hFFFFF);
        send_group(1, 1, 1);
        send_group(26399, 26399, 26399);
        send_group(12000, 12000, 12000);
        wait_drained();
        write_register(REG_RREF, 20'd0);
        write_register(REG_BETA, 20'd0);
        write_register(REG_T0, 20'd0);
        send_group(500, 500, 500);
        send_group(25000, 25000, 25000);
        wait_drained();
    endtask

    task automatic test_random(int groups, bit idle);
        allow_idle = idle;
        for (int g = 0; g < groups; g++)
        begin
            if (g % 60 == 0)
            begin
                wait_drained();
                write_register(REG_RREF, 20'($urandom_range(1, 1000000)));
                write_register(REG_BETA, 20'($urandom_range(1, 10000)));
                write_register(REG_T0, 20'($urandom_range(1, 50000)));
            end
            send_sample(random_sample());
            send_sample(random_sample());
            send_sample(random_sample());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_valid = 1'b0;
        sample = '0;
        rref_model = 20'd10000;
        beta_model = 14'd3950;
        t0_model = 16'd29815;
        group_pos = 0;
        failures = 0;
        allow_idle = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_registers();
        test_random(420, 1'b1);
        wait_drained();
        test_random(120, 1'b0);
        wait_drained();
        if (failures == 0)
            $display("ntc_median3_temperature_test passed");
        else
            $display("ntc_median3_temperature_test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!allow_idle)
                result_stall <= 1'b0;
            else if (idle_cycles > 0)
            begin
                idle_cycles <= idle_cycles - 1;
                result_stall <= (idle_cycles > 1);
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                idle_cycles <= $urandom_range(1, 11);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("unexpected transaction", status, -1);
            else
            begin
                want = expected_readings.pop_front();
                if (temperature !== want.temp)
                    report_mismatch("temperature", temperature, want.temp);
                if (thermistor_resistance !== want.ohms)
                    report_mismatch("resistance", thermistor_resistance, want.ohms);
                if (status !== want.stat)
                    report_mismatch("status", status, want.stat);
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("ntc_median3_temperature_test failed");
            $finish;
        end
    end
endmodule

// ===== ntc_median3_temperature.f =====
+incdir+sv
sv/ntcm_pkg.sv
sv/ntcm_front.sv
sv/ntcm_fifo.sv
sv/ntcm_engine.sv
sv/ntc_median3_temperature.sv
sv/ntcm_checker.sv
verif/ntc_median3_temperature_test.sv
